### sv/sliding_window_anagram_match_macros.svh
// assertion macros for the sliding window anagram matcher
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SWAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SWAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/swam_pkg.sv
// types and constants shared by the anagram matcher modules
`timescale 1ns / 1ps

package swam_pkg;

  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned OP_W          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [LETTER_W-1:0] letter;
  } in_beat_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic pattern_overflow;
  } out_beat_t;

  typedef struct packed {
    logic                clear_all;
    logic                clear_window;
    logic                pat_inc;
    logic                txt_inc;
    logic                txt_drop;
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] old_letter;
  } hist_ctrl_t;

endpackage

### sv/sliding_window_anagram_match.sv
// top level of the sliding window anagram matcher
`timescale 1ns / 1ps

// Streams clear, pattern-letter and text-letter beats and returns one result
// beat per input beat: window match, sticky found and sticky pattern overflow.
// One beat is taken every cycle unless the output stalls; each beat passes the
// input register, then the single pass through the 26 histogram lanes and their
// compare into the result register. The delay line holding the window letters
// is read ahead from the updated pointer through its registered port, so it
// never holds up the stream. Stall on the output backs up into in_stall_o.
module sliding_window_anagram_match
  import swam_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  `include "sliding_window_anagram_match_macros.svh"

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned PTR_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned SUM_W = LEN_W + 1;

  // input stage
  logic     s1_valid_q;
  in_beat_t s1_beat_q;

  // result stage
  logic      out_valid_q;
  out_beat_t out_beat_q;

  // search state
  logic [LEN_W-1:0] pattern_length_q, pattern_length_d;
  logic [LEN_W-1:0] text_seen_q, text_seen_d;
  logic [PTR_W-1:0] write_pos_q, write_pos_d;
  logic             found_q, found_d;
  logic             overflow_q, overflow_d;

  logic advance;
  logic fire;
  logic letter_ok;
  logic is_clear;
  logic is_pat;
  logic is_txt;
  logic pat_full;
  logic len_zero;
  logic pat_acc;
  logic txt_act;
  logic win_full;
  logic drop;
  logic hist_eq;
  logic match;

  logic [SUM_W-1:0]    old_sum;
  logic [SUM_W-1:0]    old_wrap;
  logic [PTR_W-1:0]    raddr;
  logic [LETTER_W-1:0] old_letter;
  hist_ctrl_t          hist_ctrl;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_beat_q <= in_beat_i;
    end
  end

  // decode
  assign letter_ok = (s1_beat_q.letter < LETTER_W'(ALPHABET_SIZE));
  assign is_clear  = fire && (s1_beat_q.op == OP_CLEAR);
  assign is_pat    = fire && (s1_beat_q.op == OP_PATTERN) && letter_ok;
  assign is_txt    = fire && (s1_beat_q.op == OP_TEXT) && letter_ok;
  assign pat_full  = (pattern_length_q == LEN_W'(MAX_PATTERN_LEN));
  assign len_zero  = (pattern_length_q == '0);
  assign pat_acc   = is_pat && !pat_full;
  assign txt_act   = is_txt && !len_zero;
  assign win_full  = (text_seen_q >= pattern_length_q);
  assign drop      = txt_act && win_full;

  always_comb begin
    pattern_length_d = pattern_length_q;
    text_seen_d      = text_seen_q;
    write_pos_d      = write_pos_q;
    overflow_d       = overflow_q;
    if (is_clear) begin
      pattern_length_d = '0;
      text_seen_d      = '0;
      write_pos_d      = '0;
      overflow_d       = 1'b0;
    end else if (pat_acc) begin
      pattern_length_d = pattern_length_q + LEN_W'(1);
      text_seen_d      = '0;
    end else if (is_pat) begin
      overflow_d = 1'b1;
    end else if (txt_act) begin
      if (!win_full) begin
        text_seen_d = text_seen_q + LEN_W'(1);
      end
      if (write_pos_q == PTR_W'(MAX_PATTERN_LEN - 1)) begin
        write_pos_d = '0;
      end else begin
        write_pos_d = write_pos_q + PTR_W'(1);
      end
    end
  end

  assign match = is_txt && (len_zero || ((text_seen_d == pattern_length_q) && hist_eq));

  always_comb begin
    found_d = found_q;
    if (is_clear) begin
      found_d = 1'b0;
    end else if (match) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      text_seen_q      <= '0;
      write_pos_q      <= '0;
      found_q          <= 1'b0;
      overflow_q       <= 1'b0;
    end else begin
      pattern_length_q <= pattern_length_d;
      text_seen_q      <= text_seen_d;
      write_pos_q      <= write_pos_d;
      found_q          <= found_d;
      overflow_q       <= overflow_d;
    end
  end

  // oldest window letter for the next beat, taken from the updated state
  assign old_sum  = SUM_W'(write_pos_d) + SUM_W'(MAX_PATTERN_LEN) - SUM_W'(pattern_length_d);
  assign old_wrap = (old_sum >= SUM_W'(MAX_PATTERN_LEN)) ? old_sum - SUM_W'(MAX_PATTERN_LEN)
                                                          : old_sum;
  assign raddr    = old_wrap[PTR_W-1:0];

  swam_delay_line #(
    .DEPTH (MAX_PATTERN_LEN),
    .PTR_W (PTR_W)
  ) u_delay_line (
    .clk_i   (clk_i),
    .we_i    (txt_act),
    .waddr_i (write_pos_q),
    .wdata_i (s1_beat_q.letter),
    .raddr_i (raddr),
    .rdata_o (old_letter)
  );

  always_comb begin
    hist_ctrl.clear_all    = is_clear;
    hist_ctrl.clear_window = is_clear || pat_acc;
    hist_ctrl.pat_inc      = pat_acc;
    hist_ctrl.txt_inc      = txt_act;
    hist_ctrl.txt_drop     = drop;
    hist_ctrl.letter       = s1_beat_q.letter;
    hist_ctrl.old_letter   = old_letter;
  end

  swam_histogram #(
    .CNT_W (LEN_W)
  ) u_histogram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hist_ctrl),
    .hist_eq_o (hist_eq)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (advance) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_beat_q.window_match     <= match;
      out_beat_q.found            <= found_d;
      out_beat_q.pattern_overflow <= overflow_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `SWAM_ASSERT_NOW(a_stall_only_full, in_stall_o, s1_valid_q && out_valid_q, "stall with room in the pipe")
  `SWAM_ASSERT_NOW(a_seen_in_window, 1'b1, text_seen_q <= pattern_length_q, "window count past pattern length")
  `SWAM_ASSERT_NOW(a_overflow_full, overflow_q, pattern_length_q == LEN_W'(MAX_PATTERN_LEN), "overflow below full pattern")
  `SWAM_ASSERT_NEXT(a_found_sticky, found_q && !is_clear, found_q, "found dropped without a clear")

endmodule

### sv/swam_delay_line.sv
// circular letter delay line with a registered read port
`timescale 1ns / 1ps

module swam_delay_line
  import swam_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned PTR_W = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PTR_W-1:0]    waddr_i,
  input  logic [LETTER_W-1:0] wdata_i,
  input  logic [PTR_W-1:0]    raddr_i,
  output logic [LETTER_W-1:0] rdata_o
);

  logic [LETTER_W-1:0] mem_q [DEPTH];
  logic [LETTER_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-through when the next read hits the entry written now
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/swam_histogram.sv
// pattern and window letter histograms with parallel equality compare
`timescale 1ns / 1ps

module swam_histogram
  import swam_pkg::*;
#(
  parameter int unsigned CNT_W = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hist_ctrl_t ctrl_i,
  output logic       hist_eq_o
);

  logic [CNT_W-1:0]         pat_q [ALPHABET_SIZE];
  logic [CNT_W-1:0]         pat_d [ALPHABET_SIZE];
  logic [CNT_W-1:0]         win_q [ALPHABET_SIZE];
  logic [CNT_W-1:0]         win_d [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] eq;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_lane
    logic hit_new;
    logic hit_old;

    assign hit_new = (ctrl_i.letter == LETTER_W'(i));
    assign hit_old = (ctrl_i.old_letter == LETTER_W'(i));

    always_comb begin
      pat_d[i] = pat_q[i];
      if (ctrl_i.clear_all) begin
        pat_d[i] = '0;
      end else if (ctrl_i.pat_inc && hit_new) begin
        pat_d[i] = pat_q[i] + CNT_W'(1);
      end
    end

    always_comb begin
      win_d[i] = win_q[i];
      if (ctrl_i.clear_window) begin
        win_d[i] = '0;
      end else begin
        win_d[i] = win_q[i]
                 + CNT_W'(ctrl_i.txt_inc && hit_new)
                 - CNT_W'(ctrl_i.txt_drop && hit_old && (win_q[i] != '0));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pat_q[i] <= '0;
        win_q[i] <= '0;
      end else begin
        pat_q[i] <= pat_d[i];
        win_q[i] <= win_d[i];
      end
    end

    // window after this beat against the pattern
    assign eq[i] = (win_d[i] == pat_q[i]);
  end

  assign hist_eq_o = &eq;

endmodule
